>>> sv/bq_pkg.sv
// Shared constants, payload types and control types of the biquad filter.
package bq_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEF_WIDTH_DEF  = 18;
  localparam int DELAY_WIDTH     = 40;
  localparam int DIGIT_WIDTH     = 4;
  localparam int NUM_DIGITS      = (SAMPLE_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
  localparam int SHIFT_WIDTH     = NUM_DIGITS * DIGIT_WIDTH;
  localparam int CNT_WIDTH       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int NUM_COEF        = 5;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_ROUND,
    ST_MUL_Y,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           mode;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;
  } out_t;

  // Per-lane MAC control.
  typedef struct packed {
    logic load_acc;
    logic load_mcand;
    logic step;
    logic last;
  } mac_ctrl_t;

endpackage

>>> sv/bq_coef_regs.sv
// Coefficient register file written through the configuration port.
module bq_coef_regs #(
  parameter int COEF_WIDTH = bq_pkg::COEF_WIDTH_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           cfg_valid_i,
  output logic                                           cfg_ready_o,
  input  logic [bq_pkg::CFG_INDEX_WIDTH-1:0]             cfg_index_i,
  input  logic [COEF_WIDTH-1:0]                          cfg_data_i,
  output logic [bq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0]    coef_o
);

  // Unity gain in Q3.(COEF_WIDTH-4)
  localparam logic [COEF_WIDTH-1:0] CoefOne = COEF_WIDTH'(1) << (COEF_WIDTH - 4);
  // b0 sits in the lowest slot; every other coefficient resets to zero
  localparam logic [bq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0] CoefReset =
    {{((bq_pkg::NUM_COEF - 1) * COEF_WIDTH){1'b0}}, CoefOne};

  logic [bq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0] coef_q, coef_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bq_pkg::COEF_B0: coef_d[bq_pkg::COEF_B0] = cfg_data_i;
        bq_pkg::COEF_B1: coef_d[bq_pkg::COEF_B1] = cfg_data_i;
        bq_pkg::COEF_B2: coef_d[bq_pkg::COEF_B2] = cfg_data_i;
        bq_pkg::COEF_A1: coef_d[bq_pkg::COEF_A1] = cfg_data_i;
        bq_pkg::COEF_A2: coef_d[bq_pkg::COEF_A2] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CoefReset;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> sv/bq_mac.sv
// Digit-serial multiply-accumulate lane: one multiplier digit per cycle while step is set.
module bq_mac #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                                clk_i,
  input  bq_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [ACC_WIDTH-1:0]         acc_init_i,
  input  logic signed [ACC_WIDTH-1:0]         mcand_init_i,
  input  logic [bq_pkg::DIGIT_WIDTH-1:0]      digit_i,
  output logic signed [ACC_WIDTH-1:0]         acc_o
);

  localparam int DW = bq_pkg::DIGIT_WIDTH;

  logic signed [ACC_WIDTH-1:0] acc_q, acc_d;
  logic signed [ACC_WIDTH-1:0] mcand_q, mcand_d;
  logic signed [DW:0]          digit_s;
  logic signed [ACC_WIDTH+DW:0] prod;

  always_comb begin
    // top digit carries the sample's sign, lower digits are unsigned
    digit_s = {ctrl_i.last & digit_i[DW-1], digit_i};
    prod    = mcand_q * digit_s;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    if (ctrl_i.load_acc) begin
      acc_d = acc_init_i;
    end else if (ctrl_i.step) begin
      acc_d = acc_q + prod[ACC_WIDTH-1:0];
    end
    if (ctrl_i.load_mcand) begin
      mcand_d = mcand_init_i;
    end else if (ctrl_i.step) begin
      mcand_d = mcand_q <<< DW;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
  end

  assign acc_o = acc_q;

endmodule

>>> sv/biquad_iir_filter.sv
// Top level of the transposed direct form II biquad section.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | in        | in_valid_i / in_stall_o   | in_data_i  (sample_in, mode)
//  out     | out       | out_valid_o / out_stall_i | out_data_o (sample_out, clipped)
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A transaction steps through the x products, one digit at a time, the
// rounding of y, the y products, write-back and the taking of the next
// sample. The digit-serial MAC lanes take one digit per cycle: all three
// during the x products, lanes 1 and 2 during the y products.
// A clear transaction (mode = 1) goes from taking its sample to write-back.
// Reset zeroes both delays, loads b0 = 1.0 and the other coefficients 0.
// A stalled result waits in the output register; the next sample is taken
// meanwhile and its result holds in write-back until the register frees.
module biquad_iir_filter #(
  parameter int COEF_WIDTH = bq_pkg::COEF_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bq_pkg::in_t                         in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bq_pkg::out_t                        out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bq_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index_i,
  input  logic [COEF_WIDTH-1:0]               cfg_data_i
);

  localparam int SW       = bq_pkg::SAMPLE_WIDTH;
  localparam int DLW      = bq_pkg::DELAY_WIDTH;
  localparam int DW       = bq_pkg::DIGIT_WIDTH;
  localparam int CoefFrac = COEF_WIDTH - 4;
  localparam int ProdSpan = SW + COEF_WIDTH + DW;
  localparam int AccWidth = ((DLW > ProdSpan) ? DLW : ProdSpan) + 2;

  localparam logic [AccWidth-1:0] RoundHalf = AccWidth'(1) << (CoefFrac - 1);
  localparam logic [SW-1:0]       SampleMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0]       SampleMin = {1'b1, {(SW-1){1'b0}}};
  localparam logic [DLW-1:0]      DelayMax  = {1'b0, {(DLW-1){1'b1}}};
  localparam logic [DLW-1:0]      DelayMin  = {1'b1, {(DLW-1){1'b0}}};

  // ---------------------------------------------------------------------
  // Coefficients
  // ---------------------------------------------------------------------
  logic [bq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0] coef;

  bq_coef_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  logic signed [AccWidth-1:0] b0_ext, b1_ext, b2_ext, a1_neg, a2_neg;

  assign b0_ext = AccWidth'($signed(coef[bq_pkg::COEF_B0]));
  assign b1_ext = AccWidth'($signed(coef[bq_pkg::COEF_B1]));
  assign b2_ext = AccWidth'($signed(coef[bq_pkg::COEF_B2]));
  // feedback terms enter the lanes negated, so every lane only adds
  assign a1_neg = -AccWidth'($signed(coef[bq_pkg::COEF_A1]));
  assign a2_neg = -AccWidth'($signed(coef[bq_pkg::COEF_A2]));

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  bq_pkg::state_e state_q, state_d;

  logic [bq_pkg::CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                         last_digit;
  logic                         accept;
  logic                         out_free;
  logic                         retire;
  logic                         out_valid_q, out_valid_d;
  bq_pkg::mac_ctrl_t            ctrl_ff, ctrl_fb;

  assign last_digit = (cnt_q == bq_pkg::CNT_WIDTH'(bq_pkg::NUM_DIGITS - 1));
  assign out_free   = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_data_i.mode ? bq_pkg::ST_DONE : bq_pkg::ST_MUL_X;
        end
      end
      bq_pkg::ST_MUL_X: begin
        if (last_digit) state_d = bq_pkg::ST_ROUND;
      end
      bq_pkg::ST_ROUND: begin
        state_d = bq_pkg::ST_MUL_Y;
      end
      bq_pkg::ST_MUL_Y: begin
        if (last_digit) state_d = bq_pkg::ST_DONE;
      end
      bq_pkg::ST_DONE: begin
        if (out_free) state_d = bq_pkg::ST_IDLE;
      end
      default: state_d = bq_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    retire     = 1'b0;
    ctrl_ff    = '0;
    ctrl_fb    = '0;
    unique case (state_q)
      bq_pkg::ST_IDLE: begin
        in_stall_o         = 1'b0;
        accept             = in_valid_i;
        ctrl_ff.load_acc   = in_valid_i;
        ctrl_ff.load_mcand = in_valid_i;
        ctrl_fb.load_acc   = in_valid_i;
        ctrl_fb.load_mcand = in_valid_i;
      end
      bq_pkg::ST_MUL_X: begin
        ctrl_ff.step = 1'b1;
        ctrl_ff.last = last_digit;
        ctrl_fb.step = 1'b1;
        ctrl_fb.last = last_digit;
      end
      bq_pkg::ST_ROUND: begin
        ctrl_fb.load_mcand = 1'b1;
      end
      bq_pkg::ST_MUL_Y: begin
        ctrl_fb.step = 1'b1;
        ctrl_fb.last = last_digit;
      end
      bq_pkg::ST_DONE: begin
        retire = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept || state_q == bq_pkg::ST_ROUND) begin
      cnt_d = '0;
    end else if (state_q == bq_pkg::ST_MUL_X || state_q == bq_pkg::ST_MUL_Y) begin
      cnt_d = cnt_q + bq_pkg::CNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bq_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------
  // Digit shift register: x during the first pass, y during the second
  // ---------------------------------------------------------------------
  logic [bq_pkg::SHIFT_WIDTH-1:0] dsh_q, dsh_d;
  logic signed [SW-1:0]           y_q, y_d;
  logic                           clip_q, clip_d;
  logic                           clr_q, clr_d;

  always_comb begin
    dsh_d = dsh_q;
    if (accept) begin
      dsh_d = bq_pkg::SHIFT_WIDTH'($signed(in_data_i.sample_in));
    end else if (state_q == bq_pkg::ST_ROUND) begin
      dsh_d = bq_pkg::SHIFT_WIDTH'(y_d);
    end else if (state_q == bq_pkg::ST_MUL_X || state_q == bq_pkg::ST_MUL_Y) begin
      dsh_d = dsh_q >> DW;
    end
  end

  // ---------------------------------------------------------------------
  // MAC lanes
  //   lane 0: d1 + b0*x           -> y
  //   lane 1: d2 + b1*x - a1*y    -> new d1
  //   lane 2:      b2*x - a2*y    -> new d2
  // ---------------------------------------------------------------------
  logic signed [DLW-1:0]      d1_q, d1_d, d2_q, d2_d;
  logic signed [AccWidth-1:0] acc0, acc1, acc2;
  logic signed [AccWidth-1:0] mc1_init, mc2_init;
  logic [DW-1:0]              digit;

  assign digit    = dsh_q[DW-1:0];
  assign mc1_init = (state_q == bq_pkg::ST_ROUND) ? a1_neg : b1_ext;
  assign mc2_init = (state_q == bq_pkg::ST_ROUND) ? a2_neg : b2_ext;

  bq_mac #(.ACC_WIDTH (AccWidth)) u_mac0 (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl_ff),
    .acc_init_i   (AccWidth'(d1_q)),
    .mcand_init_i (b0_ext),
    .digit_i      (digit),
    .acc_o        (acc0)
  );

  bq_mac #(.ACC_WIDTH (AccWidth)) u_mac1 (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl_fb),
    .acc_init_i   (AccWidth'(d2_q)),
    .mcand_init_i (mc1_init),
    .digit_i      (digit),
    .acc_o        (acc1)
  );

  bq_mac #(.ACC_WIDTH (AccWidth)) u_mac2 (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl_fb),
    .acc_init_i   ('0),
    .mcand_init_i (mc2_init),
    .digit_i      (digit),
    .acc_o        (acc2)
  );

  // ---------------------------------------------------------------------
  // Round half up, then saturate to the sample width
  // ---------------------------------------------------------------------
  logic signed [AccWidth-1:0] rnd, rsh;
  logic                       y_ovf;

  always_comb begin
    rnd   = acc0 + $signed(RoundHalf);
    rsh   = rnd >>> CoefFrac;
    y_ovf = !((&rsh[AccWidth-1:SW-1]) || !(|rsh[AccWidth-1:SW-1]));
    y_d   = y_ovf ? (rsh[AccWidth-1] ? SampleMin : SampleMax) : rsh[SW-1:0];
    clip_d = y_ovf;
  end

  assign clr_d = accept ? in_data_i.mode : clr_q;

  always_ff @(posedge clk_i) begin
    dsh_q <= dsh_d;
    clr_q <= clr_d;
    if (state_q == bq_pkg::ST_ROUND) begin
      y_q    <= y_d;
      clip_q <= clip_d;
    end
  end

  // ---------------------------------------------------------------------
  // Delay update with 40-bit saturation
  // ---------------------------------------------------------------------
  logic d1_ovf, d2_ovf;

  always_comb begin
    d1_ovf = !((&acc1[AccWidth-1:DLW-1]) || !(|acc1[AccWidth-1:DLW-1]));
    d2_ovf = !((&acc2[AccWidth-1:DLW-1]) || !(|acc2[AccWidth-1:DLW-1]));
    d1_d   = d1_q;
    d2_d   = d2_q;
    if (retire) begin
      if (clr_q) begin
        d1_d = '0;
        d2_d = '0;
      end else begin
        d1_d = d1_ovf ? (acc1[AccWidth-1] ? DelayMin : DelayMax) : acc1[DLW-1:0];
        d2_d = d2_ovf ? (acc2[AccWidth-1] ? DelayMin : DelayMax) : acc2[DLW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else begin
      d1_q <= d1_d;
      d2_q <= d2_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  bq_pkg::out_t out_data_q, out_data_d;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (retire) begin
      out_valid_d = 1'b1;
      if (clr_q) begin
        out_data_d = '0;
      end else begin
        out_data_d.sample_out = y_q;
        out_data_d.clipped    = clip_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // a result only appears after write-back
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == bq_pkg::ST_DONE))
    else $error("result raised outside write-back");

  // a taken sample starts work at once
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != bq_pkg::ST_IDLE))
    else $error("sample taken but sequencer stayed idle");

  // a clear transaction zeroes the result and both delays
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && clr_q) |=>
      (out_data_o.sample_out == '0 && !out_data_o.clipped && d1_q == '0 && d2_q == '0))
    else $error("clear transaction left state or result nonzero");

  // a clipped result sits on a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.clipped) |->
      (out_data_o.sample_out == SampleMax || out_data_o.sample_out == SampleMin))
    else $error("clipped result not at full scale");
`endif

endmodule

>>> bench/tb.sv
// Self-checking testbench for the biquad_iir_filter section.
module tb;
  import bq_pkg::*;

  localparam int CW        = COEF_WIDTH_DEF;
  localparam int COEF_FRAC = CW - 4;  // Q3.14 coefficients

  localparam logic [CW-1:0] COEF_MAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COEF_MIN   = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] COEF_UNITY = CW'(1 << COEF_FRAC);
  localparam logic [CW-1:0] COEF_HALF  = CW'(1 << (COEF_FRAC - 1));

  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  localparam int RANDOM_PHASES    = 14;
  localparam int ITEMS_PER_PHASE  = 125;
  localparam int HOLD_CYCLES      = 250;
  localparam int HOLD_AFTER       = 300;  // results checked before the long hold-off
  localparam int SENDER_GAP_MAX   = 12;

  // Tracks filter state and coefficients; holds the outputs still owed by the block.
  class biquad_checker;
    longint coef [NUM_COEF];
    longint delay_first, delay_second;
    out_t   expected_samples [$];
    int     errors, outputs_checked, clears_sent, clips_expected;

    function new();
      coef = '{longint'(COEF_UNITY), 0, 0, 0, 0};
      delay_first  = 0;
      delay_second = 0;
    endfunction

    function void set_coef(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] val);
      if (idx < NUM_COEF) coef[idx] = longint'($signed(val));
    endfunction

    function longint clamp_to(longint v, int w, output bit hit);
      longint hi, lo;
      hi  = (longint'(1) << (w - 1)) - 1;
      lo  = -hi - 1;
      hit = 1'b0;
      if (v > hi) begin
        hit = 1'b1;
        return hi;
      end
      if (v < lo) begin
        hit = 1'b1;
        return lo;
      end
      return v;
    endfunction

    // y = round(b0*x + d1), then d1 = b1*x - a1*y + d2, d2 = b2*x - a2*y
    function out_t predict_biquad(in_t item);
      longint x, acc, y, nd1, nd2;
      bit     clip, dummy;
      out_t   res;
      res = '0;
      if (item.mode) begin
        delay_first  = 0;
        delay_second = 0;
        return res;
      end
      x   = longint'($signed(item.sample_in));
      acc = coef[COEF_B0] * x + delay_first + (longint'(1) << (COEF_FRAC - 1));
      y   = clamp_to(acc >>> COEF_FRAC, SAMPLE_WIDTH, clip);
      nd1 = coef[COEF_B1] * x - coef[COEF_A1] * y + delay_second;
      nd2 = coef[COEF_B2] * x - coef[COEF_A2] * y;
      delay_first  = clamp_to(nd1, DELAY_WIDTH, dummy);
      delay_second = clamp_to(nd2, DELAY_WIDTH, dummy);
      res.sample_out = y[SAMPLE_WIDTH-1:0];
      res.clipped    = clip;
      return res;
    endfunction

    function void take_sample(in_t item);
      out_t exp_out;
      exp_out = predict_biquad(item);
      if (item.mode) clears_sent++;
      if (exp_out.clipped) clips_expected++;
      expected_samples.push_back(exp_out);
    endfunction

    function void check_output(out_t got);
      out_t exp_out;
      outputs_checked++;
      if (expected_samples.size() == 0) begin
        $error("output with no sample pending: sample_out %0d clipped %0b",
               $signed(got.sample_out), got.clipped);
        errors++;
        return;
      end
      exp_out = expected_samples.pop_front();
      if (got.sample_out !== exp_out.sample_out) begin
        $error("sample_out: expected %0d, got %0d",
               $signed(exp_out.sample_out), $signed(got.sample_out));
        errors++;
      end
      if (got.clipped !== exp_out.clipped) begin
        $error("clipped: expected %0b, got %0b", exp_out.clipped, got.clipped);
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  in_t                        in_data_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  out_t                       out_data_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i;
  logic [CW-1:0]              cfg_data_i;

  biquad_checker chk = new();

  // Sender burst state, receiver stall and hold-off state, and a count of coefficient writes.
  int burst_left   = 0;
  int gap_max      = SENDER_GAP_MAX;
  int coef_writes  = 0;
  int rx_cycle     = 0;
  int stall_mode   = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  biquad_iir_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("timeout: filter stopped making progress");
    $display("*** FAILED ***");
    $finish;
  end

  // One coefficient write; the checker's copy changes only once the
  // write transaction is accepted.
  task automatic write_coef(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [CW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    chk.set_coef(idx, val);
    coef_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offers one sample transaction. The sender runs in bursts; a new burst
  // may open with a random gap (gap_max of zero means back-to-back).
  task automatic feed_sample(input logic [SAMPLE_WIDTH-1:0] s, input logic m);
    int  gap;
    in_t item;
    item.sample_in = s;
    item.mode      = m;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = item;
    do @(posedge clk_i); while (in_stall_o);
    chk.take_sample(item);
  endtask

  // Stop offering and let every owed output drain; every sample yields
  // exactly one output, so an empty queue means the block is idle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // kind 0: full-range coefficients, 1: mostly stable filter, 2: corner values.
  // Except with kind 2, some registers keep their old value; now and then an unused index is hit.
  task automatic load_filter(input int kind);
    logic [CW-1:0] v;
    coef_idx_e     idx;
    for (int i = 0; i < NUM_COEF; i++) begin
      idx = coef_idx_e'(i);
      if (kind != 2 && $urandom_range(0, 3) == 0) continue;
      case (kind)
        0: v = CW'($urandom);
        1: begin
          case (idx)
            COEF_A1: v = CW'(int'($urandom_range(0, 60000)) - 30000);
            COEF_A2: v = CW'($urandom_range(0, 15000));
            default: v = CW'(int'($urandom_range(0, 32768)) - 16384);
          endcase
        end
        default: begin
          case ($urandom_range(0, 3))
            0: v = COEF_MAX;
            1: v = COEF_MIN;
            2: v = '0;
            default: v = COEF_UNITY;
          endcase
        end
      endcase
      write_coef(idx, v);
    end
    if ($urandom_range(0, 3) == 0)
      write_coef(CFG_INDEX_WIDTH'($urandom_range(NUM_COEF, 2**CFG_INDEX_WIDTH - 1)), CW'($urandom));
  endtask

  // Receiver: the stall pattern is redrawn periodically from none, light
  // random, heavy random and periodic. Once, after HOLD_AFTER results, it
  // stalls until hold_left runs out, so the block backs up into its input.
  initial begin
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (!hold_done && chk.outputs_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (rx_cycle % 100 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall_i = 1'b0;
          1:       out_stall_i = ($urandom_range(0, 7) == 0);
          2:       out_stall_i = ($urandom_range(0, 3) != 0);
          default: out_stall_i = ((rx_cycle % 7) < 3);
        endcase
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) chk.check_output(out_data_o);
    end
  end

  // Main sequence: directed corners first, then random phases, each phase
  // opened with a fresh coefficient set written while the block is idle.
  initial begin
    logic [SAMPLE_WIDTH-1:0] s;
    logic                    m;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset coefficients: unity pass-through, sample extremes, and a clear
    // whose sample must be ignored.
    feed_sample('0, 1'b0);
    feed_sample(SAMPLE_MAX, 1'b0);
    feed_sample(SAMPLE_MIN, 1'b0);
    feed_sample(SAMPLE_WIDTH'(1), 1'b0);
    feed_sample(SAMPLE_WIDTH'(-1), 1'b0);
    feed_sample(SAMPLE_MAX, 1'b1);
    wait_idle();

    // b0 = 0.5: +1 from zero delays lands exactly on a half and rounds up.
    write_coef(COEF_B0, COEF_HALF);
    write_coef(COEF_B1, COEF_UNITY);
    write_coef(COEF_B2, -COEF_UNITY);
    write_coef(COEF_A1, -COEF_HALF);
    write_coef(COEF_A2, CW'(4096));
    feed_sample(SAMPLE_WIDTH'(1), 1'b0);
    feed_sample(SAMPLE_WIDTH'(-1), 1'b0);
    feed_sample(SAMPLE_WIDTH'(3), 1'b0);
    feed_sample(SAMPLE_WIDTH'(12345), 1'b0);
    feed_sample(SAMPLE_WIDTH'(-3), 1'b1);
    wait_idle();

    // Coefficient extremes: output saturates both ways, and the saturated
    // output feeds back into the delays.
    write_coef(COEF_B0, COEF_MAX);
    write_coef(COEF_B1, COEF_MIN);
    write_coef(COEF_B2, COEF_MAX);
    write_coef(COEF_A1, COEF_MIN);
    write_coef(COEF_A2, COEF_MAX);
    feed_sample(SAMPLE_MAX, 1'b0);
    feed_sample(SAMPLE_MIN, 1'b0);
    feed_sample(SAMPLE_MAX, 1'b0);
    feed_sample('0, 1'b0);
    feed_sample(SAMPLE_WIDTH'(-1), 1'b0);
    feed_sample(SAMPLE_MIN, 1'b1);
    feed_sample(SAMPLE_WIDTH'(100), 1'b0);
    wait_idle();

    // Most negative b0; writes to unused indexes must leave state alone.
    write_coef(COEF_B0, COEF_MIN);
    for (int i = NUM_COEF; i < 2**CFG_INDEX_WIDTH; i++)
      write_coef(CFG_INDEX_WIDTH'(i), CW'($urandom));
    feed_sample(SAMPLE_MAX, 1'b0);
    feed_sample(SAMPLE_MIN, 1'b0);
    feed_sample(SAMPLE_WIDTH'(1), 1'b0);
    feed_sample(SAMPLE_WIDTH'(-1), 1'b0);
    feed_sample('0, 1'b0);
    wait_idle();

    // Random phases. Clears are sparse so the recursion has time to build up.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_filter((p == RANDOM_PHASES - 1) ? 2 : $urandom_range(0, 2));
      gap_max = (p % 4 == 1) ? 0 : SENDER_GAP_MAX;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 7))
          0:       s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
          1, 2:    s = SAMPLE_WIDTH'(int'($urandom_range(0, 512)) - 256);
          default: s = SAMPLE_WIDTH'($urandom);
        endcase
        m = ($urandom_range(0, 19) == 0);
        feed_sample(s, m);
      end
      wait_idle();
    end

    repeat (30) @(posedge clk_i);

    $display("checked %0d outputs (%0d clears, %0d saturated) over %0d coefficient writes",
             chk.outputs_checked, chk.clears_sent, chk.clips_expected, coef_writes);
    $display("sender bursts and gaps, receiver stall patterns and one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (chk.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bq_pkg.sv
sv/bq_coef_regs.sv
sv/bq_mac.sv
sv/biquad_iir_filter.sv
bench/tb.sv
